// ===== rtl/core/bbd_pkg.sv =====
`default_nettype none
package bbd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int PIX_W          = 8;
    localparam int POS_W          = 12;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_NORTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_EAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_SOUTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_WEST  = 3'd5;

    localparam logic [CFG_W-1:0] IMAGE_DIM_RESET = 13'd4096;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_PIX,
        KIND_DRAIN
    } kind_t;

    // 3x3 neighborhood, index row*3+col, center at 4
    typedef logic [8:0][PIX_W-1:0] nbhd_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t             rgb;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } out_item_t;

    // truncated mean of up to four samples; divide by 3 via reciprocal
    function automatic logic [PIX_W-1:0] mean(input logic [9:0] sum, input logic [2:0] cnt);
        logic [19:0]      prod;
        logic [PIX_W-1:0] res;
        prod = 20'(sum) * 20'd683;
        unique case (cnt)
            3'd1:    res = sum[7:0];
            3'd2:    res = sum[8:1];
            3'd3:    res = prod[18:11];
            3'd4:    res = sum[9:2];
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic rgb_t demosaic(input nbhd_t n, input logic rodd, input logic codd,
                                      input logic up, input logic down,
                                      input logic left, input logic right);
        logic [9:0]       ds, vs, hs, xs;
        logic [2:0]       dc, vc, hc, xc;
        logic [PIX_W-1:0] dg, cr, ve, ho;
        rgb_t             o;
        ds = '0; dc = '0; vs = '0; vc = '0; hs = '0; hc = '0;
        if (up && left)    begin ds = ds + 10'(n[0]); dc = dc + 3'd1; end
        if (up && right)   begin ds = ds + 10'(n[2]); dc = dc + 3'd1; end
        if (down && left)  begin ds = ds + 10'(n[6]); dc = dc + 3'd1; end
        if (down && right) begin ds = ds + 10'(n[8]); dc = dc + 3'd1; end
        if (up)    begin vs = vs + 10'(n[1]); vc = vc + 3'd1; end
        if (down)  begin vs = vs + 10'(n[7]); vc = vc + 3'd1; end
        if (left)  begin hs = hs + 10'(n[3]); hc = hc + 3'd1; end
        if (right) begin hs = hs + 10'(n[5]); hc = hc + 3'd1; end
        xs = vs + hs;
        xc = vc + hc;
        dg = mean(ds, dc);
        cr = mean(xs, xc);
        ve = mean(vs, vc);
        ho = mean(hs, hc);
        unique case ({rodd, codd})
            2'b00:   begin o.red = dg;   o.green = cr;   o.blue = n[4]; end
            2'b01:   begin o.red = ve;   o.green = n[4]; o.blue = ho;   end
            2'b10:   begin o.red = ho;   o.green = n[4]; o.blue = ve;   end
            default: begin o.red = n[4]; o.green = cr;   o.blue = dg;   end
        endcase
        return o;
    endfunction

    function automatic logic border_hit(input logic [31:0] r, input logic [31:0] c,
                                        input logic [31:0] bn, input logic [31:0] be,
                                        input logic [31:0] bs, input logic [31:0] bw,
                                        input logic [31:0] w, input logic [31:0] h);
        return (r < bn) || (r + bs >= h) || (c < bw) || (c + be >= w);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bbd_ram.sv =====
`default_nettype none
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] addr_b,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-first; output holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[addr_a];
            rdata_b <= mem[addr_b];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bayer_bggr_border_demosaic_core.sv =====
`default_nettype none
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+-------------------------------------------
// input    | in  | in_valid / in_ready    | opcode, raw_pixel
// result   | out | out_valid / out_ready  | red, green, blue, pixel_row, pixel_col,
//          |     |                        | last_of_run
// config   | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always 1)
//
// One request per cycle: read of both line RAMs at accept, modify/write from the
// RAM stage register, then a two-entry result register. A row end that yields two
// results stalls the input; the line RAM read-write loop sets the rate. Results
// pass from the RAM stage into the result register. Reset clears counters,
// window and valids; line RAMs need no clearing. Output stalls back up through
// the result register into the RAM stage, whose read data holds.
module bayer_bggr_border_demosaic_core #(
    parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           opcode,
    input  wire logic [bbd_pkg::PIX_W-1:0]      raw_pixel,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [bbd_pkg::PIX_W-1:0]      red,
    output logic      [bbd_pkg::PIX_W-1:0]      green,
    output logic      [bbd_pkg::PIX_W-1:0]      blue,
    output logic      [bbd_pkg::POS_W-1:0]      pixel_row,
    output logic      [bbd_pkg::POS_W-1:0]      pixel_col,
    output logic                                last_of_run,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = bbd_pkg::PIX_W;

    // configuration
    logic [bbd_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [bbd_pkg::CFG_W-1:0] bn_reg, be_reg, bs_reg, bw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbd_pkg::IMAGE_DIM_RESET;
            height_reg <= bbd_pkg::IMAGE_DIM_RESET;
            bn_reg     <= '0;
            be_reg     <= '0;
            bs_reg     <= '0;
            bw_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bbd_pkg::REG_IMAGE_WIDTH)  width_reg  <= cfg_data;
            if (cfg_index == bbd_pkg::REG_IMAGE_HEIGHT) height_reg <= cfg_data;
            if (cfg_index == bbd_pkg::REG_BORDER_NORTH) bn_reg     <= cfg_data;
            if (cfg_index == bbd_pkg::REG_BORDER_EAST)  be_reg     <= cfg_data;
            if (cfg_index == bbd_pkg::REG_BORDER_SOUTH) bs_reg     <= cfg_data;
            if (cfg_index == bbd_pkg::REG_BORDER_WEST)  bw_reg     <= cfg_data;
        end
    end

    // effective dimensions, clamped to 1..MAX
    logic [31:0] w32, h32;
    always_comb
    begin
        if (width_reg == '0)                      w32 = 32'd1;
        else if (32'(width_reg) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
        else                                      w32 = 32'(width_reg);
        if (height_reg == '0)                       h32 = 32'd1;
        else if (32'(height_reg) > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
        else                                        h32 = 32'(height_reg);
    end

    // position counters
    logic [CW-1:0] in_col_reg, in_col_next, drain_col_reg, drain_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic          full_reg, full_next;

    // RAM stage request
    logic                s1_valid_reg;
    bbd_pkg::kind_t      s1_kind_reg, kind;
    logic [PW-1:0]       s1_px_reg;
    logic [CW-1:0]       s1_col_reg, s1_ecol0_reg;
    logic [RW-1:0]       s1_erow_reg;
    logic                s1_e0_reg, s1_e1_reg, s1_up_reg;
    logic                s1_left0_reg, s1_right0_reg, s1_left1_reg;

    logic                accept, s1_adv, s2_free;
    logic                row_end, pix_ok, drain_ok;
    logic [31:0]         c32, r32, d32;
    logic [CW-1:0]       addr_a, addr_b;
    logic [CW-1:0]       ecol0;
    logic [RW-1:0]       erow;
    logic                e0, e1, up, left0, right0, left1;

    assign accept = in_valid && in_ready;
    assign c32    = 32'(in_col_reg);
    assign r32    = 32'(in_row_reg);
    assign d32    = 32'(drain_col_reg);

    always_comb
    begin
        pix_ok         = !opcode && !full_reg;
        drain_ok       = opcode && full_reg;
        row_end        = (c32 + 32'd1) >= w32;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        drain_col_next = drain_col_reg;
        full_next      = full_reg;
        kind           = bbd_pkg::KIND_NOP;
        e0 = 1'b0; e1 = 1'b0; up = 1'b0; left0 = 1'b0; right0 = 1'b0; left1 = 1'b0;
        erow   = in_row_reg - RW'(1);
        ecol0  = in_col_reg - CW'(1);
        addr_a = in_col_reg;
        if ((d32 + 32'd1) < 32'(MAX_WIDTH)) addr_b = drain_col_reg + CW'(1);
        else                                addr_b = CW'(MAX_WIDTH - 1);
        if (pix_ok)
        begin
            kind   = bbd_pkg::KIND_PIX;
            e0     = (r32 >= 32'd1) && (c32 >= 32'd1);
            e1     = (r32 >= 32'd1) && row_end;
            up     = r32 >= 32'd2;
            left0  = c32 >= 32'd2;
            right0 = c32 < w32;
            left1  = c32 >= 32'd1;
            if (row_end)
            begin
                in_col_next = '0;
                if ((r32 + 32'd1) >= h32) full_next   = 1'b1;
                else                      in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        else if (drain_ok)
        begin
            kind   = bbd_pkg::KIND_DRAIN;
            addr_a = drain_col_reg;
            erow   = in_row_reg;
            ecol0  = drain_col_reg;
            e0     = 1'b1;
            up     = r32 >= 32'd1;
            left0  = d32 >= 32'd1;
            right0 = (d32 + 32'd1) < w32;
            if ((d32 + 32'd1) >= w32)
            begin
                drain_col_next = '0;
                in_row_next    = '0;
                in_col_next    = '0;
                full_next      = 1'b0;
            end
            else
            begin
                drain_col_next = drain_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            drain_col_reg <= '0;
            full_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_col_reg    <= in_col_next;
                in_row_reg    <= in_row_next;
                drain_col_reg <= drain_col_next;
                full_reg      <= full_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= kind;
            s1_px_reg     <= raw_pixel;
            s1_col_reg    <= addr_a;
            s1_erow_reg   <= erow;
            s1_ecol0_reg  <= ecol0;
            s1_e0_reg     <= e0;
            s1_e1_reg     <= e1;
            s1_up_reg     <= up;
            s1_left0_reg  <= left0;
            s1_right0_reg <= right0;
            s1_left1_reg  <= left1;
        end
    end

    // line RAMs with write-to-read forwarding
    logic          wr_en;
    logic [PW-1:0] old_rd_a, old_rd_b, new_rd_a, new_rd_b;
    logic [PW-1:0] old_a, old_b, new_a, new_b;
    logic          fwd_a_reg, fwd_b_reg;
    logic [PW-1:0] fwd_old_reg, fwd_new_reg;

    assign wr_en = s1_adv && (s1_kind_reg == bbd_pkg::KIND_PIX);

    bbd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_older (
        .clk(clk), .re(accept), .addr_a(addr_a), .addr_b(addr_b),
        .we(wr_en), .waddr(s1_col_reg), .wdata(new_a),
        .rdata_a(old_rd_a), .rdata_b(old_rd_b)
    );

    bbd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_newer (
        .clk(clk), .re(accept), .addr_a(addr_a), .addr_b(addr_b),
        .we(wr_en), .waddr(s1_col_reg), .wdata(s1_px_reg),
        .rdata_a(new_rd_a), .rdata_b(new_rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_a_reg <= wr_en && (s1_col_reg == addr_a);
            fwd_b_reg <= wr_en && (s1_col_reg == addr_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_old_reg <= new_a;
            fwd_new_reg <= s1_px_reg;
        end
    end

    assign old_a = fwd_a_reg ? fwd_old_reg : old_rd_a;
    assign new_a = fwd_a_reg ? fwd_new_reg : new_rd_a;
    assign old_b = fwd_b_reg ? fwd_old_reg : old_rd_b;
    assign new_b = fwd_b_reg ? fwd_new_reg : new_rd_b;

    // window and drain history
    bbd_pkg::nbhd_t win_reg, nw, n0, n1;
    logic [PW-1:0]  mid_old_reg, mid_new_reg;

    always_comb
    begin
        nw = '0;
        for (int i = 0; i < 3; i++)
        begin
            nw[i*3]   = win_reg[i*3+1];
            nw[i*3+1] = win_reg[i*3+2];
        end
        nw[2] = old_a;
        nw[5] = new_a;
        nw[8] = s1_px_reg;
        n1 = '0;
        for (int i = 0; i < 3; i++)
        begin
            n1[i*3]   = nw[i*3+1];
            n1[i*3+1] = nw[i*3+2];
        end
        if (s1_kind_reg == bbd_pkg::KIND_DRAIN)
        begin
            n0    = '0;
            n0[0] = mid_old_reg;
            n0[3] = mid_new_reg;
            n0[1] = old_a;
            n0[4] = new_a;
            n0[2] = old_b;
            n0[5] = new_b;
        end
        else
        begin
            n0 = nw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (wr_en)
        begin
            win_reg <= nw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_kind_reg == bbd_pkg::KIND_DRAIN))
        begin
            mid_old_reg <= old_a;
            mid_new_reg <= new_a;
        end
    end

    // results of this request
    logic                 is_pix, hit0, hit1, v0, v1;
    bbd_pkg::rgb_t        rgb0, rgb1;
    bbd_pkg::out_item_t   it0, it1;
    logic [CW-1:0]        ecol1;

    assign is_pix = s1_kind_reg == bbd_pkg::KIND_PIX;
    assign ecol1  = s1_col_reg;

    always_comb
    begin
        rgb0 = bbd_pkg::demosaic(n0, s1_erow_reg[0], s1_ecol0_reg[0], s1_up_reg, is_pix,
                                 s1_left0_reg, s1_right0_reg);
        rgb1 = bbd_pkg::demosaic(n1, s1_erow_reg[0], ecol1[0], s1_up_reg, 1'b1,
                                 s1_left1_reg, 1'b0);
        hit0 = bbd_pkg::border_hit(32'(s1_erow_reg), 32'(s1_ecol0_reg), 32'(bn_reg),
                                   32'(be_reg), 32'(bs_reg), 32'(bw_reg), w32, h32);
        hit1 = bbd_pkg::border_hit(32'(s1_erow_reg), 32'(ecol1), 32'(bn_reg),
                                   32'(be_reg), 32'(bs_reg), 32'(bw_reg), w32, h32);
        v0 = (s1_kind_reg != bbd_pkg::KIND_NOP) && s1_e0_reg && hit0;
        v1 = is_pix && s1_e1_reg && hit1;
        it0.rgb  = rgb0;
        it0.row  = bbd_pkg::POS_W'(32'(s1_erow_reg));
        it0.col  = bbd_pkg::POS_W'(32'(s1_ecol0_reg));
        it0.last = !v1;
        it1.rgb  = rgb1;
        it1.row  = bbd_pkg::POS_W'(32'(s1_erow_reg));
        it1.col  = bbd_pkg::POS_W'(32'(ecol1));
        it1.last = 1'b1;
    end

    // two-entry result register
    bbd_pkg::out_item_t res0_reg, res0_next, res1_reg, res1_next;
    logic [1:0]         cnt_reg, cnt_next;

    assign s2_free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        res0_next = res0_reg;
        res1_next = res1_reg;
        cnt_next  = cnt_reg;
        if (s1_adv)
        begin
            res0_next = v0 ? it0 : it1;
            res1_next = it1;
            cnt_next  = 2'(v0) + 2'(v1);
        end
        else if (out_valid && out_ready)
        begin
            res0_next = res1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign out_valid   = cnt_reg != 2'd0;
    assign red         = res0_reg.rgb.red;
    assign green       = res0_reg.rgb.green;
    assign blue        = res0_reg.rgb.blue;
    assign pixel_row   = res0_reg.row;
    assign pixel_col   = res0_reg.col;
    assign last_of_run = res0_reg.last;

endmodule
`default_nettype wire
